// File: rtl/pvcm_pkg.sv
// shared types, constants and tables of the panorama view coordinate map
`timescale 1ns / 1ps
package pvcm_pkg;

	localparam int FRACTION_BITS_DEF = 8;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ANG_BITS          = 14;
	localparam int GUARD_BITS        = 8;
	localparam int CORDIC_W          = 28;
	localparam int ANGLE_W           = 18;
	localparam int DY_W              = 25;
	localparam int INV_GAIN          = 39797;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 16;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_LENGTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SCALE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_CENTER   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_ANGLE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_OFFSET   = 3'd6;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
	} pvcm_in_t;

	typedef struct packed {
		logic signed [15:0] source_column;
		logic [7:0]         column_fraction;
		logic [11:0]        source_row;
		logic [7:0]         row_fraction;
	} pvcm_out_t;

	// arctangent of 2^-i in q0.14 radians, rounded to nearest
	function automatic logic [13:0] atan_q14(input int i);
		logic [13:0] v;
		case (i)
			0:       v = 14'd12868;
			1:       v = 14'd7596;
			2:       v = 14'd4014;
			3:       v = 14'd2037;
			4:       v = 14'd1023;
			5:       v = 14'd512;
			6:       v = 14'd256;
			7:       v = 14'd128;
			8:       v = 14'd64;
			9:       v = 14'd32;
			10:      v = 14'd16;
			11:      v = 14'd8;
			12:      v = 14'd4;
			13:      v = 14'd2;
			14:      v = 14'd1;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/pvcm_cordic_cell.sv
// one vectoring cordic micro-rotation with its pipeline register
`timescale 1ns / 1ps
module pvcm_cordic_cell import pvcm_pkg::*; #(
	parameter int STAGE = 0,
	parameter int W     = CORDIC_W,
	parameter int TAG_W = DY_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic signed [W-1:0]       in_x,
	input  logic signed [W-1:0]       in_y,
	input  logic signed [ANGLE_W-1:0] in_a,
	input  logic [TAG_W-1:0]          in_tag,
	output logic                      out_valid,
	output logic signed [W-1:0]       out_x,
	output logic signed [W-1:0]       out_y,
	output logic signed [ANGLE_W-1:0] out_a,
	output logic [TAG_W-1:0]          out_tag
);
	localparam logic signed [ANGLE_W-1:0] ATAN = ANGLE_W'(atan_q14(STAGE));

	logic signed [W-1:0] sx, sy;

	// arithmetic shift is the floor shift
	assign sx = in_x >>> STAGE;
	assign sy = in_y >>> STAGE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_tag <= in_tag;
		if (!in_y[W-1]) begin
			out_x <= in_x + sy;
			out_y <= in_y - sx;
			out_a <= in_a + ATAN;
		end else begin
			out_x <= in_x - sy;
			out_y <= in_y + sx;
			out_a <= in_a - ATAN;
		end
	end

endmodule

// File: rtl/pvcm_cordic.sv
// row of cordic cells giving angle and scaled magnitude
`timescale 1ns / 1ps
module pvcm_cordic import pvcm_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF,
	parameter int W      = CORDIC_W,
	parameter int TAG_W  = DY_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic signed [W-1:0]       in_x,
	input  logic signed [W-1:0]       in_y,
	input  logic [TAG_W-1:0]          in_tag,
	output logic                      out_valid,
	output logic signed [W-1:0]       out_x,
	output logic signed [ANGLE_W-1:0] out_a,
	output logic [TAG_W-1:0]          out_tag
);
	logic                      v [STAGES+1];
	logic signed [W-1:0]       x [STAGES+1];
	logic signed [W-1:0]       y [STAGES+1];
	logic signed [ANGLE_W-1:0] a [STAGES+1];
	logic [TAG_W-1:0]          t [STAGES+1];

	assign v[0] = in_valid;
	assign x[0] = in_x;
	assign y[0] = in_y;
	assign a[0] = '0;
	assign t[0] = in_tag;

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		pvcm_cordic_cell #(.STAGE(i), .W(W), .TAG_W(TAG_W)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v[i]),
			.in_x      (x[i]),
			.in_y      (y[i]),
			.in_a      (a[i]),
			.in_tag    (t[i]),
			.out_valid (v[i+1]),
			.out_x     (x[i+1]),
			.out_y     (y[i+1]),
			.out_a     (a[i+1]),
			.out_tag   (t[i+1])
		);
	end

	assign out_valid = v[STAGES];
	assign out_x     = x[STAGES];
	assign out_a     = a[STAGES];
	assign out_tag   = t[STAGES];

endmodule

// File: rtl/panorama_view_coordinate_map_top.sv
// top level of the panorama view coordinate map
//
// channel   direction  handshake            word
// pixel     in         start & !busy        pvcm_in_t  (pixel_x, pixel_y)
// result    out        done, one cycle      pvcm_out_t (column, row, weights)
// cfg       in         cfg_we               cfg_index, cfg_data
//
// one pixel word accepted every cycle while busy is low
// words pass the two cordic cell rows (longitude, then latitude)
// busy is high only in the first cycle after reset, then stays low
// results cannot be stalled: done pulses for one cycle per accepted word
`timescale 1ns / 1ps
module panorama_view_coordinate_map_top import pvcm_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  pvcm_in_t              pixel,
	output logic                  done,
	output pvcm_out_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int LATENCY = 2 * CORDIC_STAGES + 4;
	localparam int W = CORDIC_W;

	// configuration registers
	logic [11:0] half_width_q, half_height_q, angle_scale_q, row_center_q;
	logic [15:0] focal_length_q;
	logic [14:0] bias_angle_q;
	logic [13:0] pan_offset_q;
	logic        ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q   <= 12'd700;
			half_height_q  <= 12'd600;
			focal_length_q <= 16'd5222;
			angle_scale_q  <= 12'd1304;
			row_center_q   <= 12'd2048;
			bias_angle_q   <= 15'd17157;
			pan_offset_q   <= 14'd0;
			ready_q        <= 1'b0;
		end else begin
			ready_q <= 1'b1;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HALF_WIDTH:   half_width_q   <= cfg_data[11:0];
					REG_HALF_HEIGHT:  half_height_q  <= cfg_data[11:0];
					REG_FOCAL_LENGTH: focal_length_q <= cfg_data;
					REG_ANGLE_SCALE:  angle_scale_q  <= cfg_data[11:0];
					REG_ROW_CENTER:   row_center_q   <= cfg_data[11:0];
					REG_BIAS_ANGLE:   bias_angle_q   <= cfg_data[14:0];
					REG_PAN_OFFSET:   pan_offset_q   <= cfg_data[13:0];
					default: ;  // unknown index: write dropped
				endcase
			end
		end
	end

	assign busy = !ready_q;

	logic accept;
	assign accept = start && !busy;

	// stage 1: offsets in 12.4 pixels with guard bits
	logic                    v_s1;
	logic signed [W-1:0]     x_s1, y_s1;
	logic [DY_W-1:0]         dy_s1;
	logic signed [12:0]      dx, dy;
	logic [15:0]             z;

	assign dx = $signed({1'b0, half_width_q}) - $signed({1'b0, pixel.pixel_x});
	assign dy = $signed({1'b0, pixel.pixel_y}) - $signed({1'b0, half_height_q});
	assign z  = (focal_length_q == 16'd0) ? 16'd1 : focal_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		x_s1  <= $signed(W'({z, {GUARD_BITS{1'b0}}}));
		y_s1  <= W'($signed({dx, {(4 + GUARD_BITS){1'b0}}}));
		dy_s1 <= {dy, {(4 + GUARD_BITS){1'b0}}};
	end

	// longitude row
	logic                      v_lon;
	logic signed [W-1:0]       mag_lon;
	logic signed [ANGLE_W-1:0] lon;
	logic [DY_W-1:0]           dy_lon;

	pvcm_cordic #(.STAGES(CORDIC_STAGES), .W(W), .TAG_W(DY_W)) u_lon (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_x      (x_s1),
		.in_y      (y_s1),
		.in_tag    (dy_s1),
		.out_valid (v_lon),
		.out_x     (mag_lon),
		.out_a     (lon),
		.out_tag   (dy_lon)
	);

	// gain correction of the magnitude
	logic                      v_s2;
	logic signed [W-1:0]       mag_s2, dyw_s2;
	logic signed [ANGLE_W-1:0] lon_s2;
	logic signed [W+17:0]      gain_prod;

	assign gain_prod = mag_lon * $signed({1'b0, 17'(INV_GAIN)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_lon;
		end
	end

	always_ff @(posedge clk) begin
		mag_s2 <= gain_prod[W+15:16];
		dyw_s2 <= W'($signed(dy_lon));
		lon_s2 <= lon;
	end

	// latitude row, longitude rides along
	logic                      v_lat;
	logic signed [ANGLE_W-1:0] lat;
	logic [ANGLE_W-1:0]        lon_lat;

	pvcm_cordic #(.STAGES(CORDIC_STAGES), .W(W), .TAG_W(ANGLE_W)) u_lat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_x      (mag_s2),
		.in_y      (dyw_s2),
		.in_tag    (lon_s2),
		.out_valid (v_lat),
		.out_x     (),
		.out_a     (lat),
		.out_tag   (lon_lat)
	);

	// scale angles to q14 pixels
	logic               v_s3;
	logic signed [32:0] col_s3, row_s3;
	logic signed [18:0] ang_diff;
	logic signed [31:0] col_prod, row_prod;

	assign ang_diff = $signed({4'b0, bias_angle_q}) - 19'($signed(lon_lat));
	// products formed at full width
	assign col_prod = $signed({1'b0, angle_scale_q}) * ang_diff;
	assign row_prod = $signed({1'b0, angle_scale_q}) * lat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_lat;
		end
	end

	always_ff @(posedge clk) begin
		col_s3 <= 33'(col_prod)
			+ $signed(33'({pan_offset_q, {ANG_BITS{1'b0}}}));
		row_s3 <= 33'(row_prod)
			+ $signed(33'({row_center_q, {ANG_BITS{1'b0}}}));
	end

	// split into floor and weight, saturate row
	logic [FRACTION_BITS-1:0] col_top, row_top;
	logic [7:0]               col_w8, row_w8;
	logic [FRACTION_BITS+7:0] col_wide, row_wide;

	assign col_top  = col_s3[ANG_BITS-1 -: FRACTION_BITS];
	assign row_top  = row_s3[ANG_BITS-1 -: FRACTION_BITS];
	assign col_wide = {col_top, 8'b0} >> FRACTION_BITS;
	assign row_wide = {row_top, 8'b0} >> FRACTION_BITS;
	assign col_w8   = col_wide[7:0];
	assign row_w8   = row_wide[7:0];

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		result.source_column   <= col_s3[ANG_BITS+15:ANG_BITS];
		result.column_fraction <= col_w8;
		if (row_s3[32]) begin
			// above the panorama top
			result.source_row   <= 12'd0;
			result.row_fraction <= 8'd0;
		end else if (row_s3[31:ANG_BITS+12] != '0) begin
			// below the last row
			result.source_row   <= 12'd4095;
			result.row_fraction <= 8'd0;
		end else begin
			result.source_row   <= row_s3[ANG_BITS+11:ANG_BITS];
			result.row_fraction <= row_w8;
		end
	end

	assign done = done_q;

	// every strobe traces back to one accepted word
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result strobe without matching accepted word");

	a_no_done_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!ready_q |-> !done)
		else $error("result strobe before block ready");

	a_row_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !row_s3[32] && row_s3[31:ANG_BITS+12] != '0)
			|=> (result.source_row == 12'd4095 && result.row_fraction == 8'd0))
		else $error("row saturation not applied");

endmodule
